/* sv/pamf_pkg.sv */
`timescale 1ns / 1ps
// Shared constants of the period-averaging frequency meter: field widths,
// operation and register index codes, and register reset values. No dependencies.
package pamf_pkg;

    localparam int CAPTURE_W  = 16;
    localparam int MS_W       = 16;
    localparam int FACTOR_W   = 40;
    localparam int QUOT_W     = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 40;

    // Item operation codes.
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_EDGE = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_PERIOD      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PERIOD      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MILLIHZ_FACTOR  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_EDGE_TIMEOUT    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_UPDATE_INTERVAL = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_STARTUP_HOLD    = 3'd5;

    // Register values after reset.
    localparam logic [CAPTURE_W-1:0] RST_MIN_PERIOD      = 16'd18182;
    localparam logic [CAPTURE_W-1:0] RST_MAX_PERIOD      = 16'd22222;
    localparam logic [FACTOR_W-1:0]  RST_MILLIHZ_FACTOR  = 40'd1000000000;
    localparam logic [MS_W-1:0]      RST_EDGE_TIMEOUT    = 16'd100;
    localparam logic [MS_W-1:0]      RST_UPDATE_INTERVAL = 16'd500;
    localparam logic [MS_W-1:0]      RST_STARTUP_HOLD    = 16'd6000;

    localparam logic [MS_W-1:0] MS_SAT = '1;

endpackage

/* sv/pamf_div.sv */
`timescale 1ns / 1ps
// Restoring divider for the frequency meter: one quotient bit per cycle with
// saturation to 32 bits detected up front. Depends on pamf_pkg.
module pamf_div
    import pamf_pkg::*;
#(
    parameter int NUM_W = 49,
    parameter int DEN_W = 24
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [NUM_W-1:0]  i_numerator,
    input  logic [DEN_W-1:0]  i_denominator,
    output logic              o_done,
    output logic [QUOT_W-1:0] o_quotient
);

    localparam int HI_W  = NUM_W - QUOT_W;
    localparam int CMP_W = (HI_W > DEN_W) ? HI_W : DEN_W;
    localparam int CNT_W = $clog2(QUOT_W);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [DEN_W-1:0]  r_rem;
    logic [DEN_W-1:0]  r_den;
    logic [QUOT_W-1:0] r_quot;

    logic [HI_W-1:0]   num_hi;
    logic              sat;
    logic [DEN_W:0]    trial;
    logic [DEN_W:0]    diff;
    logic              ge;

    always_comb begin
        num_hi = i_numerator[NUM_W-1:QUOT_W];
        // The quotient overflows 32 bits exactly when the upper part of the
        // numerator is not below the divisor.
        sat    = CMP_W'(num_hi) >= CMP_W'(i_denominator);
        trial  = {r_rem, r_quot[QUOT_W-1]};
        ge     = trial >= {1'b0, r_den};
        diff   = trial - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt  <= '0;
                r_busy <= !sat;
                r_done <= sat;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(QUOT_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_den <= i_denominator;
            if (sat) begin
                r_quot <= '1;
            end else begin
                r_rem  <= DEN_W'(num_hi);
                r_quot <= i_numerator[QUOT_W-1:0];
            end
        end else if (r_busy) begin
            r_rem  <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            r_quot <= {r_quot[QUOT_W-2:0], ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quot;

endmodule

/* sv/period_average_frequency_meter.sv */
`timescale 1ns / 1ps
// Top level of the period-averaging mains frequency meter: period ring memory,
// millisecond counters and update control. Depends on pamf_pkg and pamf_div.
//
// The meter takes one transaction per item on its input channel: either a
// millisecond tick or a rising edge carrying a 16-bit free-running timer
// capture, and returns exactly one result transaction per item with the
// current frequency in millihertz, its valid flag and an update marker. An
// edge forms the wrap-safe period since the previous capture; a period
// between the minimum and maximum registers replaces the oldest entry of a
// ring of RING_DEPTH periods held in a single-port synchronous memory, and a
// running sum is kept alongside it. An edge reads the oldest entry as it is
// accepted, then in the edge state updates the sum and writes the new period
// back. Ticks that do not recompute present their result in the cycle after
// they are accepted. A tick that recomputes multiplies the factor by
// RING_DEPTH in one registered stage and then divides by the sum in a
// restoring divider that resolves one quotient bit per cycle, or that flags
// a saturated quotient up front; the result is presented when the divider
// is done. The ring needs no clearing pass after reset: entries are written
// strictly in order, so a flag that records the first full lap tells whether
// the entry being replaced has been written yet; an unwritten one is taken
// as zero.
// A new transaction is accepted while the previous result is being taken.
// Configuration registers may be written at any time the meter is idle.
module period_average_frequency_meter
    import pamf_pkg::*;
#(
    parameter int RING_DEPTH = 256
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Configuration write port.
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    // Input channel.
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic                  i_operation,
    input  logic [CAPTURE_W-1:0]  i_timer_capture,
    // Result channel.
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [QUOT_W-1:0]     o_frequency_millihz,
    output logic                  o_valid_res,
    output logic                  o_updated
);

    localparam int IDX_W = $clog2(RING_DEPTH);
    // The sum of RING_DEPTH 16-bit periods always fits in this width.
    localparam int SUM_W = CAPTURE_W + IDX_W;
    localparam int NUM_W = FACTOR_W + $clog2(RING_DEPTH + 1);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_EDGE  = 2'd1;
    localparam logic [1:0] S_MUL   = 2'd2;
    localparam logic [1:0] S_DIV   = 2'd3;

    // Control and state registers.
    logic [1:0]           r_state,        n_state;
    logic                 r_div_start,    n_div_start;
    logic [CAPTURE_W-1:0] r_min_period,   n_min_period;
    logic [CAPTURE_W-1:0] r_max_period,   n_max_period;
    logic [FACTOR_W-1:0]  r_factor,       n_factor;
    logic [MS_W-1:0]      r_timeout,      n_timeout;
    logic [MS_W-1:0]      r_interval,     n_interval;
    logic [MS_W-1:0]      r_hold,         n_hold;
    logic [CAPTURE_W-1:0] r_last_capture, n_last_capture;
    logic [IDX_W-1:0]     r_wr_idx,       n_wr_idx;
    logic                 r_wrapped,      n_wrapped;
    logic [SUM_W-1:0]     r_sum,          n_sum;
    logic                 r_edge_seen,    n_edge_seen;
    logic [MS_W-1:0]      r_ms_edge,      n_ms_edge;
    logic [MS_W-1:0]      r_ms_update,    n_ms_update;
    logic [MS_W-1:0]      r_startup,      n_startup;
    logic [QUOT_W-1:0]    r_freq,         n_freq;
    logic                 r_valid_flag,   n_valid_flag;
    logic                 r_updated,      n_updated;
    logic                 r_out_valid,    n_out_valid;

    // Payload registers.
    logic [CAPTURE_W-1:0] r_period;
    logic                 r_in_range;
    logic [NUM_W-1:0]     r_num;
    logic [CAPTURE_W-1:0] r_rd_data;

    // Period ring.
    logic [CAPTURE_W-1:0] r_ring [RING_DEPTH];

    logic                 in_accept;
    logic [CAPTURE_W-1:0] period;
    logic [MS_W-1:0]      ms_edge_inc;
    logic [MS_W-1:0]      ms_update_inc;
    logic [CAPTURE_W-1:0] old_period;
    logic                 ring_we;
    logic                 div_done;
    logic [QUOT_W-1:0]    div_quot;

    assign o_in_ready = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign in_accept  = i_in_valid && o_in_ready;

    always_comb begin
        period        = i_timer_capture - r_last_capture;
        ms_edge_inc   = (r_ms_edge == MS_SAT) ? r_ms_edge : r_ms_edge + 1'b1;
        ms_update_inc = (r_ms_update == MS_SAT) ? r_ms_update : r_ms_update + 1'b1;
        // Before the first lap the replaced entry is taken as zero.
        old_period    = r_wrapped ? r_rd_data : '0;
        ring_we       = (r_state == S_EDGE) && r_in_range;
    end

    always_comb begin
        n_state        = r_state;
        n_div_start    = 1'b0;
        n_min_period   = r_min_period;
        n_max_period   = r_max_period;
        n_factor       = r_factor;
        n_timeout      = r_timeout;
        n_interval     = r_interval;
        n_hold         = r_hold;
        n_last_capture = r_last_capture;
        n_wr_idx       = r_wr_idx;
        n_wrapped      = r_wrapped;
        n_sum          = r_sum;
        n_edge_seen    = r_edge_seen;
        n_ms_edge      = r_ms_edge;
        n_ms_update    = r_ms_update;
        n_startup      = r_startup;
        n_freq         = r_freq;
        n_valid_flag   = r_valid_flag;
        n_updated      = r_updated;
        n_out_valid    = r_out_valid;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_MIN_PERIOD:      n_min_period = i_cfg_wdata[CAPTURE_W-1:0];
                CFG_MAX_PERIOD:      n_max_period = i_cfg_wdata[CAPTURE_W-1:0];
                CFG_MILLIHZ_FACTOR:  n_factor     = i_cfg_wdata[FACTOR_W-1:0];
                CFG_EDGE_TIMEOUT:    n_timeout    = i_cfg_wdata[MS_W-1:0];
                CFG_UPDATE_INTERVAL: n_interval   = i_cfg_wdata[MS_W-1:0];
                CFG_STARTUP_HOLD:    n_hold       = i_cfg_wdata[MS_W-1:0];
                default: ;
            endcase
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_updated = 1'b0;
                    if (i_operation == OP_EDGE) begin
                        // The capture is kept and the timeout restarted even
                        // when the period is rejected.
                        n_last_capture = i_timer_capture;
                        n_edge_seen    = 1'b1;
                        n_ms_edge      = '0;
                        n_state        = S_EDGE;
                    end else begin
                        n_ms_edge   = ms_edge_inc;
                        n_ms_update = ms_update_inc;
                        n_out_valid = 1'b1;
                        if (r_startup < r_hold) begin
                            n_startup = r_startup + 1'b1;
                        end else if (r_edge_seen && ms_edge_inc >= r_timeout) begin
                            n_valid_flag = 1'b0;
                        end else if (ms_update_inc >= r_interval) begin
                            n_ms_update = '0;
                            if (r_sum == '0) begin
                                n_valid_flag = 1'b0;
                            end else begin
                                n_out_valid = 1'b0;
                                n_state     = S_MUL;
                            end
                        end
                    end
                end
            end
            S_EDGE: begin
                if (r_in_range) begin
                    n_sum = r_sum - SUM_W'(old_period) + SUM_W'(r_period);
                    if (r_wr_idx == IDX_W'(RING_DEPTH - 1)) begin
                        n_wr_idx  = '0;
                        n_wrapped = 1'b1;
                    end else begin
                        n_wr_idx = r_wr_idx + 1'b1;
                    end
                end
                n_out_valid = 1'b1;
                n_state     = S_IDLE;
            end
            S_MUL: begin
                // The product is registered this cycle; the divider starts next.
                n_div_start = 1'b1;
                n_state     = S_DIV;
            end
            S_DIV: begin
                if (div_done) begin
                    n_freq       = div_quot;
                    n_valid_flag = 1'b1;
                    n_updated    = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_div_start    <= 1'b0;
            r_min_period   <= RST_MIN_PERIOD;
            r_max_period   <= RST_MAX_PERIOD;
            r_factor       <= RST_MILLIHZ_FACTOR;
            r_timeout      <= RST_EDGE_TIMEOUT;
            r_interval     <= RST_UPDATE_INTERVAL;
            r_hold         <= RST_STARTUP_HOLD;
            r_last_capture <= '0;
            r_wr_idx       <= '0;
            r_wrapped      <= 1'b0;
            r_sum          <= '0;
            r_edge_seen    <= 1'b0;
            r_ms_edge      <= '0;
            r_ms_update    <= '0;
            r_startup      <= '0;
            r_freq         <= '0;
            r_valid_flag   <= 1'b0;
            r_updated      <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_div_start    <= n_div_start;
            r_min_period   <= n_min_period;
            r_max_period   <= n_max_period;
            r_factor       <= n_factor;
            r_timeout      <= n_timeout;
            r_interval     <= n_interval;
            r_hold         <= n_hold;
            r_last_capture <= n_last_capture;
            r_wr_idx       <= n_wr_idx;
            r_wrapped      <= n_wrapped;
            r_sum          <= n_sum;
            r_edge_seen    <= n_edge_seen;
            r_ms_edge      <= n_ms_edge;
            r_ms_update    <= n_ms_update;
            r_startup      <= n_startup;
            r_freq         <= n_freq;
            r_valid_flag   <= n_valid_flag;
            r_updated      <= n_updated;
            r_out_valid    <= n_out_valid;
        end
    end

    // Edge period and window check, held for the write-back cycle.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_period   <= period;
            r_in_range <= (period >= r_min_period) && (period <= r_max_period);
        end
    end

    // Numerator of the frequency: factor times ring depth.
    always_ff @(posedge i_clk) begin
        if (r_state == S_MUL) begin
            r_num <= NUM_W'(r_factor) * NUM_W'(RING_DEPTH);
        end
    end

    // Ring memory: the entry at the write index is read every cycle, so the
    // oldest period is ready in the cycle after an edge is accepted.
    always_ff @(posedge i_clk) begin
        if (ring_we) begin
            r_ring[r_wr_idx] <= r_period;
        end
        r_rd_data <= r_ring[r_wr_idx];
    end

    pamf_div #(
        .NUM_W (NUM_W),
        .DEN_W (SUM_W)
    ) u_div (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (r_div_start),
        .i_numerator   (r_num),
        .i_denominator (r_sum),
        .o_done        (div_done),
        .o_quotient    (div_quot)
    );

    assign o_out_valid         = r_out_valid;
    assign o_frequency_millihz = r_freq;
    assign o_valid_res         = r_valid_flag;
    assign o_updated           = r_updated;

endmodule

/* sim/period_average_frequency_meter_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for period_average_frequency_meter: directed and random
// edge and tick streams, each result checked against a behavioural model of the
// meter. Depends on pamf_pkg and period_average_frequency_meter.
module period_average_frequency_meter_tb
    import pamf_pkg::*;
();

    localparam int RING_DEPTH      = 256;
    localparam int CYCLE_LIMIT     = 2_000_000;
    localparam int IDLE_PCT        = 32;
    localparam int SETTLE_CYCLES   = 64;
    localparam int MAX_REPORTS     = 100;
    localparam int RANDOM_PHASES   = 7;
    localparam int PHASE_ITEMS     = 65;
    localparam int FULL_RATE_TICKS = 24;

    // One expected result transaction.
    typedef struct packed {
        logic [QUOT_W-1:0] frequency_millihz;
        logic              valid_res;
        logic              updated;
    } t_reading;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    logic                  i_operation = OP_TICK;
    logic [CAPTURE_W-1:0]  i_timer_capture = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic [QUOT_W-1:0]     o_frequency_millihz;
    logic                  o_valid_res;
    logic                  o_updated;

    period_average_frequency_meter #(
        .RING_DEPTH(RING_DEPTH)
    ) i_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_wdata        (i_cfg_wdata),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_operation        (i_operation),
        .i_timer_capture    (i_timer_capture),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_frequency_millihz(o_frequency_millihz),
        .o_valid_res        (o_valid_res),
        .o_updated          (o_updated)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Testbench bookkeeping. When pace_random is clear, neither side idles.
    bit          pace_random = 1'b1;
    int unsigned cycle_count = 0;
    int unsigned reading_errors = 0;
    int unsigned reports_shown = 0;
    t_reading    pending_readings[$];
    logic [CAPTURE_W-1:0] mains_capture = '0;  // last capture sent on an edge

    // Register copies held by the model.
    logic [CAPTURE_W-1:0] win_min, win_max;
    logic [FACTOR_W-1:0]  tick_factor;
    logic [MS_W-1:0]      timeout_ms, interval_ms, hold_ms;

    // Meter state held by the model.
    logic [CAPTURE_W-1:0] meter_last_capture;
    logic [CAPTURE_W-1:0] period_store [RING_DEPTH];
    int                   store_slot;
    logic [23:0]          period_total;
    bit                   edge_present;
    logic [MS_W-1:0]      ms_edge, ms_update, startup_ms;
    logic [QUOT_W-1:0]    freq_now;
    bit                   freq_ok;

    // ------------------------------------------------------------------
    // Behavioural model of the meter
    // ------------------------------------------------------------------

    function automatic void reset_meter();
        win_min            = RST_MIN_PERIOD;
        win_max            = RST_MAX_PERIOD;
        tick_factor        = RST_MILLIHZ_FACTOR;
        timeout_ms         = RST_EDGE_TIMEOUT;
        interval_ms        = RST_UPDATE_INTERVAL;
        hold_ms            = RST_STARTUP_HOLD;
        meter_last_capture = '0;
        foreach (period_store[k]) period_store[k] = '0;
        store_slot         = 0;
        period_total       = '0;
        edge_present       = 1'b0;
        ms_edge            = '0;
        ms_update          = '0;
        startup_ms         = '0;
        freq_now           = '0;
        freq_ok            = 1'b0;
    endfunction

    function automatic void apply_register(input logic [CFG_IDX_W-1:0] idx,
                                           input logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_MIN_PERIOD:      win_min     = data[CAPTURE_W-1:0];
            CFG_MAX_PERIOD:      win_max     = data[CAPTURE_W-1:0];
            CFG_MILLIHZ_FACTOR:  tick_factor = data[FACTOR_W-1:0];
            CFG_EDGE_TIMEOUT:    timeout_ms  = data[MS_W-1:0];
            CFG_UPDATE_INTERVAL: interval_ms = data[MS_W-1:0];
            CFG_STARTUP_HOLD:    hold_ms     = data[MS_W-1:0];
            default: ;
        endcase
    endfunction

    // Advances the model by one transaction and returns the reading it produces.
    function automatic t_reading advance_meter(input logic op,
                                               input logic [CAPTURE_W-1:0] capture);
        t_reading             rd;
        logic [CAPTURE_W-1:0] period;
        logic [63:0]          numerator, quotient;
        rd.updated = 1'b0;
        if (op == OP_EDGE) begin
            // The period wraps with the 16-bit timer.
            period = capture - meter_last_capture;
            if (period >= win_min && period <= win_max) begin
                period_total = period_total - 24'(period_store[store_slot]) + 24'(period);
                period_store[store_slot] = period;
                store_slot = (store_slot == RING_DEPTH - 1) ? 0 : store_slot + 1;
            end
            meter_last_capture = capture;
            edge_present = 1'b1;
            ms_edge = '0;
        end else begin
            ms_edge   = (ms_edge == MS_SAT) ? ms_edge : ms_edge + 1'b1;
            ms_update = (ms_update == MS_SAT) ? ms_update : ms_update + 1'b1;
            if (startup_ms < hold_ms) begin
                startup_ms = startup_ms + 1'b1;
            end else if (edge_present && ms_edge >= timeout_ms) begin
                freq_ok = 1'b0;
            end else if (ms_update >= interval_ms) begin
                ms_update = '0;
                if (period_total == '0) begin
                    // An empty ring leaves the old frequency but drops the valid flag.
                    freq_ok = 1'b0;
                end else begin
                    numerator = 64'(tick_factor) * 64'(RING_DEPTH);
                    quotient  = numerator / 64'(period_total);
                    freq_now  = (quotient > 64'hFFFF_FFFF) ? '1 : quotient[QUOT_W-1:0];
                    freq_ok   = 1'b1;
                    rd.updated = 1'b1;
                end
            end
        end
        rd.frequency_millihz = freq_now;
        rd.valid_res = freq_ok;
        return rd;
    endfunction

    // ------------------------------------------------------------------
    // Monitor and checker
    // ------------------------------------------------------------------

    function automatic void report_mismatch(input string field, input logic [63:0] want,
                                            input logic [63:0] got);
        reading_errors++;
        if (reports_shown < MAX_REPORTS) begin
            reports_shown++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        end
    endfunction

    // Everything is sampled at the rising edge, so the values seen are those that the
    // meter saw. The input transaction is modelled before the result transaction is
    // checked, so that a result returned in the same cycle still finds its expectation.
    always @(posedge i_clk) begin : result_check
        t_reading oldest;
        if (i_rst_n) begin
            if (i_cfg_we)
                apply_register(i_cfg_index, i_cfg_wdata);
            if (i_in_valid && o_in_ready)
                pending_readings.push_back(advance_meter(i_operation, i_timer_capture));
            if (o_out_valid && i_out_ready) begin
                if (pending_readings.size() == 0) begin
                    report_mismatch("unexpected result transaction", 64'(0), 64'(1));
                end else begin
                    oldest = pending_readings.pop_front();
                    if (o_frequency_millihz !== oldest.frequency_millihz)
                        report_mismatch("frequency_millihz", 64'(oldest.frequency_millihz),
                                        64'(o_frequency_millihz));
                    if (o_valid_res !== oldest.valid_res)
                        report_mismatch("valid_res", 64'(oldest.valid_res),
                                        64'(o_valid_res));
                    if (o_updated !== oldest.updated)
                        report_mismatch("updated", 64'(oldest.updated), 64'(o_updated));
                end
            end
        end
        i_out_ready <= !pace_random || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // Sends one transaction. Valid is left high on return; the next call either keeps
    // it high with a new payload or lowers it for an idle gap, never both in one step.
    task automatic send_item(input logic op, input logic [CAPTURE_W-1:0] capture);
        while (pace_random && $urandom_range(0, 99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_operation     <= op;
        i_timer_capture <= capture;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic send_tick();
        // The capture is ignored on ticks, so it carries random noise.
        send_item(OP_TICK, CAPTURE_W'($urandom));
    endtask

    task automatic send_edge(input logic [CAPTURE_W-1:0] capture);
        mains_capture = capture;
        send_item(OP_EDGE, capture);
    endtask

    // Stops sending and waits until every expected result has been taken. The first
    // edge lets the monitor record the transaction accepted at the current edge.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_readings.size() != 0)
            @(posedge i_clk);
    endtask

    // One register write; the enable is lowered again before return, so back-to-back
    // calls never assign it twice in one step.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic program_registers(input logic [CAPTURE_W-1:0] lo,
                                     input logic [CAPTURE_W-1:0] hi,
                                     input logic [FACTOR_W-1:0] factor,
                                     input logic [MS_W-1:0] timeout,
                                     input logic [MS_W-1:0] interval,
                                     input logic [MS_W-1:0] hold);
        write_reg(CFG_MIN_PERIOD, CFG_DATA_W'(lo));
        write_reg(CFG_MAX_PERIOD, CFG_DATA_W'(hi));
        write_reg(CFG_MILLIHZ_FACTOR, CFG_DATA_W'(factor));
        write_reg(CFG_EDGE_TIMEOUT, CFG_DATA_W'(timeout));
        write_reg(CFG_UPDATE_INTERVAL, CFG_DATA_W'(interval));
        write_reg(CFG_STARTUP_HOLD, CFG_DATA_W'(hold));
    endtask

    // A mains-like stream: a few ticks, then an edge whose period mostly falls inside
    // the window. The remaining edges carry arbitrary periods, which are rejected or
    // land anywhere. Now and then the sender stops until the meter has caught up.
    task automatic run_mains_phase(input int n_items, input logic [CAPTURE_W-1:0] lo,
                                   input logic [CAPTURE_W-1:0] hi, input int max_gap);
        int                   sent;
        logic [CAPTURE_W-1:0] period;
        sent = 0;
        while (sent < n_items) begin
            repeat ($urandom_range(0, max_gap)) begin
                send_tick();
                sent++;
            end
            if (lo <= hi && $urandom_range(0, 99) < 85)
                period = CAPTURE_W'($urandom_range(hi, lo));
            else
                period = CAPTURE_W'($urandom);
            send_edge(mains_capture + period);
            sent++;
            if ($urandom_range(0, 99) < 3)
                drain_results();
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset settings: during the startup hold nothing is recomputed. The edge to zero
    // wraps the timer; both give periods far outside the window, so both are rejected.
    task automatic test_startup_hold();
        send_tick();
        send_edge(16'hFFFF);
        send_edge(16'h0000);
        send_tick();
        send_tick();
    endtask

    // With the hold released and an update due, an empty ring must clear the valid
    // flag without touching the frequency.
    task automatic test_zero_sum();
        drain_results();
        write_reg(CFG_STARTUP_HOLD, '0);
        write_reg(CFG_UPDATE_INTERVAL, CFG_DATA_W'(1));
        send_tick();
    endtask

    // Periods at both window limits are taken, those one outside and a wrapped one are
    // not. Then the largest factor saturates the quotient, a zero factor gives a zero
    // frequency that is still valid, and a zero interval recomputes on every tick.
    task automatic test_period_window();
        drain_results();
        write_reg(CFG_MIN_PERIOD, CFG_DATA_W'(100));
        write_reg(CFG_MAX_PERIOD, CFG_DATA_W'(200));
        send_edge(16'd100);
        send_edge(16'd300);
        send_edge(16'd299);
        send_edge(16'd398);
        send_edge(16'd599);
        send_tick();
        drain_results();
        write_reg(CFG_MILLIHZ_FACTOR, {CFG_DATA_W{1'b1}});
        send_tick();
        drain_results();
        write_reg(CFG_MILLIHZ_FACTOR, '0);
        write_reg(CFG_UPDATE_INTERVAL, '0);
        send_tick();
        send_tick();
    endtask

    // Edge timeout: a short timeout drops the valid flag after two silent ticks; a
    // timeout of zero drops it on the first tick after an edge.
    task automatic test_edge_timeout();
        drain_results();
        write_reg(CFG_EDGE_TIMEOUT, CFG_DATA_W'(2));
        write_reg(CFG_UPDATE_INTERVAL, CFG_DATA_W'(MS_SAT));
        send_edge(16'd799);
        send_tick();
        send_tick();
        drain_results();
        write_reg(CFG_EDGE_TIMEOUT, '0);
        send_edge(16'd999);
        send_tick();
    endtask

    // Random phases over a spread of settings, including the full window, a window
    // of a single value, an empty window, a factor of one and the largest factor, tiny
    // timeouts, the longest interval and a renewed startup hold.
    task automatic test_random_mains();
        logic [CAPTURE_W-1:0] lo, hi;
        logic [FACTOR_W-1:0]  factor;
        logic [MS_W-1:0]      timeout, interval, hold;
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            drain_results();
            case (p)
                0: begin lo = '0; hi = '1; end
                1: begin lo = '1; hi = '1; end
                2: begin lo = '1; hi = '0; end
                default: begin
                    lo = CAPTURE_W'($urandom_range(40000, 1000));
                    hi = lo + CAPTURE_W'($urandom_range(5000, 0));
                end
            endcase
            if (p == 1)
                factor = '1;
            else if (p == 3)
                factor = FACTOR_W'(1);
            else if (p % 2 == 1)
                factor = {8'($urandom_range(255, 0)), 32'($urandom)};
            else
                factor = RST_MILLIHZ_FACTOR + FACTOR_W'($urandom_range(1000000, 0));
            timeout  = (p == 4) ? MS_W'($urandom_range(4, 1))
                                : MS_W'($urandom_range(65535, 16));
            interval = (p == 5) ? MS_SAT : MS_W'($urandom_range(8, 1));
            // The hold counter carries on from where it stopped, so a hold just above
            // its present value suspends updates once more.
            hold = (p == RANDOM_PHASES - 1 && startup_ms < MS_SAT - 40)
                   ? startup_ms + MS_W'($urandom_range(30, 5)) : '0;
            program_registers(lo, hi, factor, timeout, interval, hold);
            pace_random = (p != 2);
            run_mains_phase(PHASE_ITEMS, lo, hi, (p == 4) ? 6 : 4);
            pace_random = 1'b1;
        end
    endtask

    // Full-rate stretch with neither side idling: one edge, then a run of ticks that
    // each recompute, so the divider is restarted back to back.
    task automatic test_full_rate_updates();
        drain_results();
        program_registers(16'd0, MS_SAT, RST_MILLIHZ_FACTOR, MS_SAT, MS_W'(1), '0);
        pace_random = 1'b0;
        send_edge(mains_capture + 16'd20000);
        repeat (FULL_RATE_TICKS)
            send_tick();
        pace_random = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial begin
        reset_meter();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_startup_hold();
        test_zero_sum();
        test_period_window();
        test_edge_timeout();
        test_random_mains();
        test_full_rate_updates();

        // Wait for every outstanding result, then a little longer so that a stray
        // extra transaction would still be caught.
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (reading_errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

/* sim.f */
sv/pamf_pkg.sv
sv/pamf_div.sv
sv/period_average_frequency_meter.sv
sim/period_average_frequency_meter_tb.sv
